FILE: sv/lmt_pkg.sv
// Shared types and constants for the LCD mode-timing block.
// No dependencies; used by lmt_tick, lmt_regs and the top level.
package lmt_pkg;

    // Item kinds carried on the input tuser
    typedef enum logic [1:0] {
        ACT_TICK  = 2'd0,
        ACT_READ  = 2'd1,
        ACT_WRITE = 2'd2,
        ACT_NOP   = 2'd3
    } action_t;

    // Display modes, as mirrored into status bits 1..0
    typedef enum logic [1:0] {
        MODE_HBLANK = 2'd0,
        MODE_VBLANK = 2'd1,
        MODE_OAM    = 2'd2,
        MODE_XFER   = 2'd3
    } mode_t;

    // Register numbers
    localparam logic [3:0] REG_LCDC = 4'd0;
    localparam logic [3:0] REG_STAT = 4'd1;
    localparam logic [3:0] REG_SCY  = 4'd2;
    localparam logic [3:0] REG_SCX  = 4'd3;
    localparam logic [3:0] REG_LY   = 4'd4;
    localparam logic [3:0] REG_LYC  = 4'd5;
    localparam logic [3:0] REG_DMA  = 4'd6;
    localparam logic [3:0] REG_BGP  = 4'd7;
    localparam logic [3:0] REG_OBP0 = 4'd8;
    localparam logic [3:0] REG_OBP1 = 4'd9;
    localparam logic [3:0] REG_WY   = 4'd10;
    localparam logic [3:0] REG_WX   = 4'd11;

    // Mode durations in cycles
    localparam logic [15:0] LEN_OAM    = 16'd20;
    localparam logic [15:0] LEN_XFER   = 16'd43;
    localparam logic [15:0] LEN_HBLANK = 16'd60;
    localparam logic [15:0] LEN_VLINE  = 16'd114;

    // Line numbers
    localparam logic [7:0] LINE_VBLANK = 8'd144;
    localparam logic [7:0] LINE_LAST   = 8'd153;

    localparam logic [15:0] ACC_MAX     = 16'hFFFF;
    localparam logic [7:0]  UNMAPPED_RD = 8'hFF;

    // One decoded command word presented to the register block
    typedef struct packed {
        logic       valid;
        action_t    action;
        logic [7:0] cycles;
        logic [3:0] index;
        logic [7:0] data;
    } cmd_t;

    // Timing state seen by, and produced by, the tick logic
    typedef struct packed {
        mode_t       mode;
        logic [15:0] acc;
        logic [7:0]  line;
        logic [7:0]  status;
    } timing_t;

    // State after the command, as reported in the result word
    typedef struct packed {
        logic [7:0] read_data;
        mode_t      mode;
        logic [7:0] line;
        logic [7:0] status;
        logic       vblank_entered;
    } result_t;

endpackage

FILE: sv/lcd_mode_timing_with_registers_core.sv
// Top level of the LCD mode-timing block: input register, register block, result register.
// Depends on lmt_pkg and lmt_regs.
//
// Use: each input word is a tick, a register read, a register write or a no-op,
// chosen by s_axis_tuser. A tick adds elapsed cycles to a saturating accumulator
// and makes at most one mode change (OAM scan, transfer, hblank, vblank); reads
// and writes reach the twelve byte registers. Every input word gives exactly one
// result word on the m_axis side, carrying the read byte, the mode, the line,
// the status byte and a flag for entry into vblank.
// A word passes through the input register and then the result register before
// its result is valid. Throughput is one word per cycle while m_axis_tready stays
// high. Reset puts the byte registers, the accumulator and the valid flags at
// zero and the mode at OAM scan (the status mode bits stay zero until the first
// transition). When the receiver holds m_axis_tready low the result register holds
// its word, the input register fills, and s_axis_tready then drops until the result
// is taken.
module lcd_mode_timing_with_registers_core
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,  // tick_cycles[7:0], reg_index[11:8], write_data[19:12]
    input  logic [1:0]  s_axis_tuser,  // action[1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // read_data[7:0], display_mode[9:8], current_line[17:10], status_byte[25:18],
    // vblank_entered[26]
    output logic [31:0] m_axis_tdata
);

    logic             in_valid_reg, in_valid_next;
    lmt_pkg::action_t in_action_reg;
    logic [7:0]       in_cycles_reg;
    logic [3:0]       in_index_reg;
    logic [7:0]       in_data_reg;
    logic             out_valid_reg, out_valid_next;
    lmt_pkg::result_t out_res_reg;
    logic             advance;
    logic             s_take;
    lmt_pkg::cmd_t    cmd;
    lmt_pkg::result_t res;

    // Move the input word on when the result slot is free or being emptied
    assign advance       = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = !in_valid_reg || advance;
    assign s_take        = s_axis_tvalid && s_axis_tready;

    assign in_valid_next  = s_take ? 1'b1 : (advance ? 1'b0 : in_valid_reg);
    assign out_valid_next = advance ? in_valid_reg : out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Capture the input word
    always_ff @(posedge clk)
    begin
        if (s_take)
        begin
            in_action_reg <= lmt_pkg::action_t'(s_axis_tuser);
            in_cycles_reg <= s_axis_tdata[7:0];
            in_index_reg  <= s_axis_tdata[11:8];
            in_data_reg   <= s_axis_tdata[19:12];
        end
    end

    // Command to the register block, only when it is applied
    always_comb
    begin
        cmd.valid  = in_valid_reg && advance;
        cmd.action = in_action_reg;
        cmd.cycles = in_cycles_reg;
        cmd.index  = in_index_reg;
        cmd.data   = in_data_reg;
    end

    lmt_regs u_regs
    (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .res   (res)
    );

    // Hold the result word until taken
    always_ff @(posedge clk)
    begin
        if (advance && in_valid_reg)
        begin
            out_res_reg <= res;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {5'd0, out_res_reg.vblank_entered, out_res_reg.status,
                            out_res_reg.line, out_res_reg.mode, out_res_reg.read_data};

endmodule

FILE: sv/lmt_tick.sv
// Combinational tick step: saturating accumulate and at most one mode change.
// Depends on lmt_pkg.
module lmt_tick
(
    input  lmt_pkg::timing_t cur,
    input  logic [7:0]       line_compare,
    input  logic [7:0]       cycles,
    output lmt_pkg::timing_t nxt,
    output logic             vblank_entered
);

    logic [16:0]    sum;
    logic [15:0]    acc_sat;
    logic [7:0]     line_inc;
    logic           moved;
    lmt_pkg::mode_t mode_new;
    logic [15:0]    acc_new;
    logic [7:0]     line_new;
    logic [7:0]     status_mode;

    // Add elapsed cycles, clamp at the top
    assign sum      = {1'b0, cur.acc} + {9'b0, cycles};
    assign acc_sat  = sum[16] ? lmt_pkg::ACC_MAX : sum[15:0];
    assign line_inc = cur.line + 8'd1;

    // Decide the single transition for this tick
    always_comb
    begin
        moved          = 1'b0;
        mode_new       = cur.mode;
        acc_new        = acc_sat;
        line_new       = cur.line;
        vblank_entered = 1'b0;
        case (cur.mode)
            lmt_pkg::MODE_HBLANK:
            begin
                if (acc_sat >= lmt_pkg::LEN_HBLANK)
                begin
                    acc_new  = acc_sat - lmt_pkg::LEN_HBLANK;
                    line_new = line_inc;
                    moved    = 1'b1;
                    if (line_inc == lmt_pkg::LINE_VBLANK)
                    begin
                        mode_new       = lmt_pkg::MODE_VBLANK;
                        vblank_entered = 1'b1;
                    end
                    else
                    begin
                        mode_new = lmt_pkg::MODE_OAM;
                    end
                end
            end
            lmt_pkg::MODE_VBLANK:
            begin
                if (acc_sat >= lmt_pkg::LEN_VLINE)
                begin
                    acc_new = acc_sat - lmt_pkg::LEN_VLINE;
                    if (line_inc > lmt_pkg::LINE_LAST)
                    begin
                        // past the last line: back to the top of the frame
                        line_new = 8'd0;
                        mode_new = lmt_pkg::MODE_OAM;
                        moved    = 1'b1;
                    end
                    else
                    begin
                        line_new = line_inc;
                    end
                end
            end
            lmt_pkg::MODE_OAM:
            begin
                if (acc_sat >= lmt_pkg::LEN_OAM)
                begin
                    acc_new  = acc_sat - lmt_pkg::LEN_OAM;
                    mode_new = lmt_pkg::MODE_XFER;
                    moved    = 1'b1;
                end
            end
            default:
            begin
                if (acc_sat >= lmt_pkg::LEN_XFER)
                begin
                    acc_new  = acc_sat - lmt_pkg::LEN_XFER;
                    mode_new = lmt_pkg::MODE_HBLANK;
                    moved    = 1'b1;
                end
            end
        endcase
    end

    // Mirror the mode on a change, then refresh the compare match bit
    assign status_mode = moved ? {cur.status[7:2], mode_new} : cur.status;

    always_comb
    begin
        nxt.mode   = mode_new;
        nxt.acc    = acc_new;
        nxt.line   = line_new;
        nxt.status = {status_mode[7:3], (line_new == line_compare), status_mode[1:0]};
    end

endmodule

FILE: sv/lmt_regs.sv
// Twelve byte registers plus mode and accumulator state, updated per command word.
// Depends on lmt_pkg and lmt_tick.
module lmt_regs
(
    input  logic             clk,
    input  logic             rst_n,
    input  lmt_pkg::cmd_t    cmd,
    output lmt_pkg::result_t res
);

    logic [7:0]       lcdc_reg, stat_reg, scy_reg, scx_reg, ly_reg, lyc_reg;
    logic [7:0]       dma_reg, bgp_reg, obp0_reg, obp1_reg, wy_reg, wx_reg;
    lmt_pkg::mode_t   mode_reg;
    logic [15:0]      acc_reg;

    logic [7:0]       lcdc_next, stat_next, scy_next, scx_next, ly_next, lyc_next;
    logic [7:0]       dma_next, bgp_next, obp0_next, obp1_next, wy_next, wx_next;
    lmt_pkg::mode_t   mode_next;
    logic [15:0]      acc_next;

    lmt_pkg::timing_t tick_cur, tick_nxt;
    logic             tick_vb;
    logic [7:0]       rd_mux;
    logic             is_tick, is_read, is_write;

    assign is_tick  = cmd.valid && (cmd.action == lmt_pkg::ACT_TICK);
    assign is_read  = cmd.valid && (cmd.action == lmt_pkg::ACT_READ);
    assign is_write = cmd.valid && (cmd.action == lmt_pkg::ACT_WRITE);

    // Tick step on the current timing state
    always_comb
    begin
        tick_cur.mode   = mode_reg;
        tick_cur.acc    = acc_reg;
        tick_cur.line   = ly_reg;
        tick_cur.status = stat_reg;
    end

    lmt_tick u_tick
    (
        .cur            (tick_cur),
        .line_compare   (lyc_reg),
        .cycles         (cmd.cycles),
        .nxt            (tick_nxt),
        .vblank_entered (tick_vb)
    );

    // Read mux; unmapped numbers read all ones
    always_comb
    begin
        case (cmd.index)
            lmt_pkg::REG_LCDC: rd_mux = lcdc_reg;
            lmt_pkg::REG_STAT: rd_mux = stat_reg;
            lmt_pkg::REG_SCY:  rd_mux = scy_reg;
            lmt_pkg::REG_SCX:  rd_mux = scx_reg;
            lmt_pkg::REG_LY:   rd_mux = ly_reg;
            lmt_pkg::REG_LYC:  rd_mux = lyc_reg;
            lmt_pkg::REG_DMA:  rd_mux = dma_reg;
            lmt_pkg::REG_BGP:  rd_mux = bgp_reg;
            lmt_pkg::REG_OBP0: rd_mux = obp0_reg;
            lmt_pkg::REG_OBP1: rd_mux = obp1_reg;
            lmt_pkg::REG_WY:   rd_mux = wy_reg;
            lmt_pkg::REG_WX:   rd_mux = wx_reg;
            default:           rd_mux = lmt_pkg::UNMAPPED_RD;
        endcase
    end

    // Next state: tick updates timing, write to a mapped number stores one byte
    always_comb
    begin
        lcdc_next = lcdc_reg;
        stat_next = stat_reg;
        scy_next  = scy_reg;
        scx_next  = scx_reg;
        ly_next   = ly_reg;
        lyc_next  = lyc_reg;
        dma_next  = dma_reg;
        bgp_next  = bgp_reg;
        obp0_next = obp0_reg;
        obp1_next = obp1_reg;
        wy_next   = wy_reg;
        wx_next   = wx_reg;
        mode_next = mode_reg;
        acc_next  = acc_reg;
        if (is_tick)
        begin
            mode_next = tick_nxt.mode;
            acc_next  = tick_nxt.acc;
            ly_next   = tick_nxt.line;
            stat_next = tick_nxt.status;
        end
        else if (is_write)
        begin
            case (cmd.index)
                lmt_pkg::REG_LCDC: lcdc_next = cmd.data;
                lmt_pkg::REG_STAT: stat_next = cmd.data;
                lmt_pkg::REG_SCY:  scy_next  = cmd.data;
                lmt_pkg::REG_SCX:  scx_next  = cmd.data;
                lmt_pkg::REG_LY:   ly_next   = cmd.data;
                lmt_pkg::REG_LYC:  lyc_next  = cmd.data;
                lmt_pkg::REG_DMA:  dma_next  = cmd.data;
                lmt_pkg::REG_BGP:  bgp_next  = cmd.data;
                lmt_pkg::REG_OBP0: obp0_next = cmd.data;
                lmt_pkg::REG_OBP1: obp1_next = cmd.data;
                lmt_pkg::REG_WY:   wy_next   = cmd.data;
                lmt_pkg::REG_WX:   wx_next   = cmd.data;
                default:           lcdc_next = lcdc_reg;
            endcase
        end
    end

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lcdc_reg <= 8'd0;
            stat_reg <= 8'd0;
            scy_reg  <= 8'd0;
            scx_reg  <= 8'd0;
            ly_reg   <= 8'd0;
            lyc_reg  <= 8'd0;
            dma_reg  <= 8'd0;
            bgp_reg  <= 8'd0;
            obp0_reg <= 8'd0;
            obp1_reg <= 8'd0;
            wy_reg   <= 8'd0;
            wx_reg   <= 8'd0;
            mode_reg <= lmt_pkg::MODE_OAM;
            acc_reg  <= 16'd0;
        end
        else
        begin
            lcdc_reg <= lcdc_next;
            stat_reg <= stat_next;
            scy_reg  <= scy_next;
            scx_reg  <= scx_next;
            ly_reg   <= ly_next;
            lyc_reg  <= lyc_next;
            dma_reg  <= dma_next;
            bgp_reg  <= bgp_next;
            obp0_reg <= obp0_next;
            obp1_reg <= obp1_next;
            wy_reg   <= wy_next;
            wx_reg   <= wx_next;
            mode_reg <= mode_next;
            acc_reg  <= acc_next;
        end
    end

    // Result: state after this command
    always_comb
    begin
        res.read_data      = is_read ? rd_mux : 8'd0;
        res.mode           = mode_next;
        res.line           = ly_next;
        res.status         = stat_next;
        res.vblank_entered = is_tick && tick_vb;
    end

endmodule

FILE: tb/testbench.sv
// Self-checking bench for lcd_mode_timing_with_registers_core: ticks, register reads and writes.
// Depends on lmt_pkg; a scoreboard class predicts each status word and checks it on receipt.
module testbench;

    localparam int unsigned RUN_LIMIT  = 2_000_000;
    localparam int unsigned IDLE_PCT   = 35;
    localparam int unsigned SPLIT_ITEMS = 450;
    localparam int unsigned FLOOD_ITEMS = 450;

    // Predicts the timing and register state and matches status words against it
    class lcd_timing_scoreboard;
        logic [7:0]       byte_regs [12];
        lmt_pkg::mode_t   mode;
        logic [15:0]      acc;
        lmt_pkg::result_t pending_status [$];
        int               mismatches;

        function new();
            foreach (byte_regs[i])
                byte_regs[i] = 8'h00;
            mode       = lmt_pkg::MODE_OAM;
            acc        = 16'h0000;
            mismatches = 0;
        endfunction

        function logic [7:0] line_now();
            return byte_regs[lmt_pkg::REG_LY];
        endfunction

        function int outstanding();
            return pending_status.size();
        endfunction

        // Switch mode and mirror it into the low status bits
        function void enter_mode(lmt_pkg::mode_t m);
            mode = m;
            byte_regs[lmt_pkg::REG_STAT] = {byte_regs[lmt_pkg::REG_STAT][7:2], m};
        endfunction

        // Add the elapsed cycles and make at most one mode change; true on vblank entry
        function logic advance_timing(logic [7:0] cycles);
            logic [16:0] sum;
            logic        vb;
            vb  = 1'b0;
            sum = {1'b0, acc} + {9'd0, cycles};
            acc = (sum > {1'b0, lmt_pkg::ACC_MAX}) ? lmt_pkg::ACC_MAX : sum[15:0];
            case (mode)
                lmt_pkg::MODE_HBLANK:
                    if (acc >= lmt_pkg::LEN_HBLANK)
                    begin
                        acc = acc - lmt_pkg::LEN_HBLANK;
                        byte_regs[lmt_pkg::REG_LY] = byte_regs[lmt_pkg::REG_LY] + 8'd1;
                        if (byte_regs[lmt_pkg::REG_LY] == lmt_pkg::LINE_VBLANK)
                        begin
                            enter_mode(lmt_pkg::MODE_VBLANK);
                            vb = 1'b1;
                        end
                        else
                            enter_mode(lmt_pkg::MODE_OAM);
                    end
                lmt_pkg::MODE_VBLANK:
                    if (acc >= lmt_pkg::LEN_VLINE)
                    begin
                        acc = acc - lmt_pkg::LEN_VLINE;
                        byte_regs[lmt_pkg::REG_LY] = byte_regs[lmt_pkg::REG_LY] + 8'd1;
                        // a wrap from 255 to 0 is not past the last line
                        if (byte_regs[lmt_pkg::REG_LY] > lmt_pkg::LINE_LAST)
                        begin
                            byte_regs[lmt_pkg::REG_LY] = 8'd0;
                            enter_mode(lmt_pkg::MODE_OAM);
                        end
                    end
                lmt_pkg::MODE_OAM:
                    if (acc >= lmt_pkg::LEN_OAM)
                    begin
                        acc = acc - lmt_pkg::LEN_OAM;
                        enter_mode(lmt_pkg::MODE_XFER);
                    end
                default:
                    if (acc >= lmt_pkg::LEN_XFER)
                    begin
                        acc = acc - lmt_pkg::LEN_XFER;
                        enter_mode(lmt_pkg::MODE_HBLANK);
                    end
            endcase
            // line-compare match bit is refreshed on every tick
            byte_regs[lmt_pkg::REG_STAT][2] =
                (byte_regs[lmt_pkg::REG_LY] == byte_regs[lmt_pkg::REG_LYC]);
            return vb;
        endfunction

        // Apply one accepted word and queue the status word it should produce
        function void note_command(lmt_pkg::action_t act, logic [7:0] cycles,
                                   logic [3:0] index, logic [7:0] data);
            lmt_pkg::result_t r;
            r.read_data      = 8'h00;
            r.vblank_entered = 1'b0;
            case (act)
                lmt_pkg::ACT_TICK:  r.vblank_entered = advance_timing(cycles);
                lmt_pkg::ACT_READ:  r.read_data = (index <= lmt_pkg::REG_WX) ?
                                                  byte_regs[index] : lmt_pkg::UNMAPPED_RD;
                lmt_pkg::ACT_WRITE: if (index <= lmt_pkg::REG_WX) byte_regs[index] = data;
                default:            ;
            endcase
            r.mode   = mode;
            r.line   = byte_regs[lmt_pkg::REG_LY];
            r.status = byte_regs[lmt_pkg::REG_STAT];
            pending_status.push_back(r);
        endfunction

        task report_mismatch(string field, int got, int want);
            mismatches++;
            if (mismatches <= 100)
                $display("mismatch on %s: got %0d, want %0d", field, got, want);
        endtask

        // Compare one received word with the oldest prediction
        task check_result_word(logic [31:0] word);
            lmt_pkg::result_t want;
            if (pending_status.size() == 0)
                report_mismatch("unexpected word", int'(word), 0);
            else
            begin
                want = pending_status.pop_front();
                if (word[7:0] !== want.read_data)
                    report_mismatch("read_data", int'(word[7:0]), int'(want.read_data));
                if (word[9:8] !== want.mode)
                    report_mismatch("display_mode", int'(word[9:8]), int'(want.mode));
                if (word[17:10] !== want.line)
                    report_mismatch("current_line", int'(word[17:10]), int'(want.line));
                if (word[25:18] !== want.status)
                    report_mismatch("status_byte", int'(word[25:18]), int'(want.status));
                if (word[26] !== want.vblank_entered)
                    report_mismatch("vblank_entered", int'(word[26]),
                                    int'(want.vblank_entered));
            end
        endtask
    endclass

    logic        clk;
    logic        rst_n         = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic [23:0] s_axis_tdata  = 24'h0;  // tick_cycles[7:0], reg_index[11:8], write_data[19:12]
    logic [1:0]  s_axis_tuser  = lmt_pkg::ACT_NOP; // action[1:0]
    logic        m_axis_tready = 1'b0;
    logic        s_axis_tready;
    logic        m_axis_tvalid;
    // read_data[7:0], display_mode[9:8], current_line[17:10], status_byte[25:18],
    // vblank_entered[26]
    logic [31:0] m_axis_tdata;
    bit          no_idle = 1'b0;

    lcd_timing_scoreboard lcd_sb = new();

    lcd_mode_timing_with_registers_core dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Take result words and stall the output side at random
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            lcd_sb.check_result_word(m_axis_tdata);
        m_axis_tready <= no_idle || ($urandom_range(0, 99) >= IDLE_PCT);
    end

    // Present one word, idling first at random, and hold it until accepted
    task automatic send_word(lmt_pkg::action_t act, logic [7:0] cycles, logic [3:0] index,
                             logic [7:0] data);
        while (!no_idle && $urandom_range(0, 99) < IDLE_PCT)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= act;
        s_axis_tdata  <= {4'h0, data, index, cycles};
        do
            @(posedge clk);
        while (s_axis_tready !== 1'b1);
        lcd_sb.note_command(act, cycles, index, data);
    endtask

    // Hold off the input side until every predicted word has arrived
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (lcd_sb.outstanding() != 0)
            @(posedge clk);
    endtask

    // One random word; a flood pushes large ticks to drive the accumulator to saturation
    task automatic send_random_item(bit flood);
        int unsigned      roll;
        logic [7:0]       cycles;
        logic [7:0]       data;
        logic [3:0]       index;
        lmt_pkg::action_t act;
        roll   = $urandom_range(0, 99);
        cycles = 8'($urandom);
        index  = 4'($urandom);
        data   = 8'($urandom);
        if (roll < (flood ? 88 : 55))
        begin
            act = lmt_pkg::ACT_TICK;
            if (flood)
                cycles = ($urandom_range(0, 3) != 0) ? 8'hFF : 8'($urandom_range(200, 255));
            else if ($urandom_range(0, 19) != 0)
                cycles = 8'($urandom_range(0, 70));
        end
        else if (roll < (flood ? 92 : 73))
            act = lmt_pkg::ACT_READ;
        else if (roll < (flood ? 98 : 95))
        begin
            act = lmt_pkg::ACT_WRITE;
            case ($urandom_range(0, 9))
                0, 1, 2:
                begin
                    // steer the line counter onto the vblank and wrap boundaries
                    index = lmt_pkg::REG_LY;
                    case ($urandom_range(0, 5))
                        0:       data = lmt_pkg::LINE_VBLANK - 8'd1;
                        1:       data = lmt_pkg::LINE_VBLANK;
                        2:       data = lmt_pkg::LINE_LAST - 8'd1;
                        3:       data = lmt_pkg::LINE_LAST;
                        4:       data = 8'hFF;
                        default: ;
                    endcase
                end
                3, 4:
                begin
                    index = lmt_pkg::REG_LYC;
                    data  = lcd_sb.line_now() + 8'($urandom_range(0, 2));
                end
                default: ;
            endcase
        end
        else
            act = lmt_pkg::ACT_NOP;
        send_word(act, cycles, index, data);
    endtask

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Status reads zero straight after reset although the mode is OAM scan
        send_word(lmt_pkg::ACT_READ,  8'h00, lmt_pkg::REG_STAT, 8'h00);
        send_word(lmt_pkg::ACT_NOP,   8'hFF, 4'hF,              8'hFF);
        send_word(lmt_pkg::ACT_TICK,  8'h00, lmt_pkg::REG_LCDC, 8'h00);
        send_word(lmt_pkg::ACT_TICK,  8'hFF, lmt_pkg::REG_LCDC, 8'h00);
        send_word(lmt_pkg::ACT_WRITE, 8'h00, lmt_pkg::REG_LCDC, 8'hFF);
        send_word(lmt_pkg::ACT_READ,  8'h00, lmt_pkg::REG_LCDC, 8'h00);
        send_word(lmt_pkg::ACT_WRITE, 8'h00, lmt_pkg::REG_WX,   8'h00);
        // Unmapped indexes: writes dropped, reads give all ones
        send_word(lmt_pkg::ACT_WRITE, 8'h00, 4'hF,              8'hA5);
        send_word(lmt_pkg::ACT_READ,  8'h00, 4'hF,              8'h00);
        send_word(lmt_pkg::ACT_READ,  8'h00, 4'hC,              8'h00);
        // Status write stores every bit, mode bits included
        send_word(lmt_pkg::ACT_WRITE, 8'h00, lmt_pkg::REG_STAT, 8'hFF);
        send_word(lmt_pkg::ACT_READ,  8'h00, lmt_pkg::REG_STAT, 8'h00);
        // Walk into vblank at line 144 with the compare matching
        send_word(lmt_pkg::ACT_WRITE, 8'h00, lmt_pkg::REG_LY,
                  lmt_pkg::LINE_VBLANK - 8'd1);
        send_word(lmt_pkg::ACT_WRITE, 8'h00, lmt_pkg::REG_LYC,  lmt_pkg::LINE_VBLANK);
        send_word(lmt_pkg::ACT_TICK,  8'hFF, lmt_pkg::REG_LCDC, 8'h00);
        send_word(lmt_pkg::ACT_TICK,  8'h00, lmt_pkg::REG_LCDC, 8'h00);
        // Line wraps from 255 to 0 and stays in vblank
        send_word(lmt_pkg::ACT_WRITE, 8'h00, lmt_pkg::REG_LY,   8'hFF);
        send_word(lmt_pkg::ACT_TICK,  8'h00, lmt_pkg::REG_LCDC, 8'h00);
        // Past the last line: back to line 0 and OAM scan
        send_word(lmt_pkg::ACT_WRITE, 8'h00, lmt_pkg::REG_LY,   lmt_pkg::LINE_LAST);
        send_word(lmt_pkg::ACT_TICK,  8'h00, lmt_pkg::REG_LCDC, 8'h00);
        send_word(lmt_pkg::ACT_READ,  8'h00, lmt_pkg::REG_LY,   8'h00);
        wait_drained();

        // Mixed traffic with small ticks, a stretch without idling and a drain midway
        for (int n = 0; n < SPLIT_ITEMS; n++)
        begin
            no_idle = (n >= 150 && n < 270);
            if (n == 225)
                wait_drained();
            send_random_item(1'b0);
        end
        no_idle = 1'b0;

        // Large ticks to drive the accumulator to saturation
        for (int n = 0; n < FLOOD_ITEMS; n++)
            send_random_item(1'b1);

        wait_drained();
        repeat (4) @(posedge clk);
        if (lcd_sb.mismatches == 0 && lcd_sb.outstanding() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    // Stop a hung run
    initial
    begin
        #(RUN_LIMIT);
        $display("Mismatches found");
        $finish;
    end

endmodule
